/* sv/tilt_complementary_filter_defines.svh */
// Assertion macros shared by the checker files of the tilt filter.
// Needs a clk and an arst_n in the scope where a macro is used.
`ifndef TILT_COMPLEMENTARY_FILTER_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TCF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tilt filter check failed");

// Check that cons holds in the cycle after ante.
`define TCF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tilt filter check failed");

`endif

/* sv/tcf_pkg.sv */
// Shared constants, types and the CORDIC angle table of the tilt filter.
// No dependencies; every file but the defines header imports it.
`default_nettype none
package tcf_pkg;

	// boxcar window, a power of two
	localparam int AVG_DEPTH = 8;
	localparam int AVG_SHIFT = $clog2(AVG_DEPTH);
	localparam int SLOT_W = (AVG_SHIFT > 0) ? AVG_SHIFT : 1;
	localparam int SUM_W = 16 + AVG_SHIFT;

	localparam int CORDIC_STEPS = 16;
	localparam int TAB_LEN = 24;
	localparam int IDX_W = 5;
	localparam int XY_W = 36;
	localparam int ANG_W = 20;
	localparam int RAD_W = 20;

	localparam int ROOT_W = 32;
	localparam int RADIC_W = 64;
	localparam int SQRT_STEPS = 32;
	localparam int CNT_W = 6;

	localparam int MUL_W = 33;
	localparam int ACC_W = 66;

	localparam int DEG_LIM = 23040;
	localparam int DEG_MUL = 3754936;

	// configuration register indexes
	localparam logic [2:0] REG_PITCH_BLEND = 3'd0;
	localparam logic [2:0] REG_ROLL_BLEND = 3'd1;
	localparam logic [2:0] REG_GYRO_STEP_X = 3'd2;
	localparam logic [2:0] REG_GYRO_STEP_Y = 3'd3;
	localparam logic [2:0] REG_ACCEL_SCALE_X = 3'd4;
	localparam logic [2:0] REG_ACCEL_SCALE_Y = 3'd5;
	localparam logic [2:0] REG_ACCEL_SCALE_Z = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_ROOT_P,
		ST_ROOT_P_W,
		ST_CORD_P,
		ST_CORD_P_W,
		ST_ROOT_R,
		ST_ROOT_R_W,
		ST_CORD_R,
		ST_CORD_R_W,
		ST_MUL_B,
		ST_FUSE,
		ST_MUL_C,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	// atan(2^-i) in Q16, rounded to nearest
	function automatic logic [ANG_W-1:0] atan_q16(input logic [IDX_W-1:0] idx);
		logic [ANG_W-1:0] v;
		case (idx)
			5'd0: v = 20'd51472;
			5'd1: v = 20'd30386;
			5'd2: v = 20'd16055;
			5'd3: v = 20'd8150;
			5'd4: v = 20'd4091;
			5'd5: v = 20'd2047;
			5'd6: v = 20'd1024;
			5'd7: v = 20'd512;
			5'd8: v = 20'd256;
			5'd9: v = 20'd128;
			5'd10: v = 20'd64;
			5'd11: v = 20'd32;
			5'd12: v = 20'd16;
			5'd13: v = 20'd8;
			5'd14: v = 20'd4;
			5'd15: v = 20'd2;
			5'd16: v = 20'd1;
			default: v = 20'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* sv/tcf_mul.sv */
// Shared signed multiplier of the tilt filter with a registered product.
// Depends on tcf_pkg for the operand width.
`default_nettype none
module tcf_mul import tcf_pkg::*; (
	input  wire logic                         clk,
	input  wire logic signed [MUL_W-1:0]      a,
	input  wire logic signed [MUL_W-1:0]      b,
	output logic signed [2*MUL_W-1:0]         p_s1
);

	// multiply and register
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule
`default_nettype wire

/* sv/tcf_isqrt.sv */
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on tcf_pkg for widths and the start/status structs.
`default_nettype none
module tcf_isqrt import tcf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire unit_ctl_t             ctl,
	input  wire logic [RADIC_W-1:0]    radicand,
	output unit_sts_t                  sts,
	output logic [ROOT_W-1:0]          root
);

	logic [RADIC_W-1:0] val_q;
	logic [ROOT_W+3:0]  rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [ROOT_W+3:0]  rem_sh;
	logic [ROOT_W+3:0]  trial;
	logic               fits;

	// bring down the next bit pair and try the next root bit
	always_comb begin
		rem_sh = {rem_q[ROOT_W+1:0], val_q[RADIC_W-1:RADIC_W-2]};
		trial = {2'b00, root_q, 2'b01};
		fits = (rem_sh >= trial);
	end

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (ctl.start) begin
			cnt_q <= CNT_W'(SQRT_STEPS);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// advance remainder and root
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			val_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[RADIC_W-3:0], 2'b00};
			if (fits) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

/* sv/tcf_cordic.sv */
// CORDIC vectoring unit: angle of (den, num) in Q16 radians, one step per cycle.
// Depends on tcf_pkg for widths, the angle table and the start/status structs.
`default_nettype none
module tcf_cordic import tcf_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire unit_ctl_t               ctl,
	input  wire logic signed [31:0]      num,
	input  wire logic [ROOT_W-1:0]       den,
	output unit_sts_t                    sts,
	output logic signed [ANG_W-1:0]      angle
);

	logic signed [XY_W-1:0]  x_q;
	logic signed [XY_W-1:0]  y_q;
	logic signed [ANG_W-1:0] z_q;
	logic [IDX_W-1:0]        i_q;
	logic                    zero_q;
	logic                    busy_q;
	logic                    done_q;

	logic signed [XY_W-1:0]  tx;
	logic signed [XY_W-1:0]  ty;
	logic signed [ANG_W-1:0] step;

	// shifted terms of this step
	always_comb begin
		tx = x_q >>> i_q;
		ty = y_q >>> i_q;
		step = $signed(atan_q16(i_q));
	end

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (ctl.start) begin
			i_q <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			i_q <= i_q + 1'b1;
			if (i_q == IDX_W'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// rotate toward the x axis
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= $signed({{(XY_W-ROOT_W){1'b0}}, den});
			y_q <= XY_W'(num);
			z_q <= '0;
			zero_q <= (num == 32'sd0) && (den == '0);
		end else if (busy_q) begin
			if (!y_q[XY_W-1]) begin
				x_q <= x_q + ty;
				y_q <= y_q - tx;
				z_q <= z_q + step;
			end else begin
				x_q <= x_q - ty;
				y_q <= y_q + tx;
				z_q <= z_q - step;
			end
		end
	end

	// a zero vector has angle zero
	assign angle = zero_q ? '0 : z_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule
`default_nettype wire

/* sv/tilt_complementary_filter.sv */
// Top level of the tilt filter: handshakes, boxcar averages, sequencer, blend.
// Depends on tcf_pkg, tcf_mul, tcf_isqrt and tcf_cordic.
//
// Use: one beat on s_axis carries accel_x/y/z and rate_x/y. The block
// averages each accelerometer axis over 8 samples, takes two tilt angles by
// square root and CORDIC, blends them with the integrated gyro rates and
// returns one beat on m_axis: pitch_deg, roll_deg (Q9.7 degrees) and the
// three averages.
// Sequence: products on the shared multiplier, then per angle a 32-step
// square root and a 16-step CORDIC pass, each with a start state and a
// wait state for its done, then the blend products, the fuse state, the
// degree products and the load of the output register.
// s_axis_tready is high only in idle, so a new sample is taken only after
// the previous result has been loaded into the output register.
// The output register frees the core: a stalled m_axis beat holds while the
// next input beat is accepted; the core waits only if it finishes first.
// cfg beats are always taken (cfg_ready high); write them while idle.
// Reset clears the boxcar windows, the angle state and the output valid, and
// loads the register defaults.
`default_nettype none
module tilt_complementary_filter import tcf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// accel_x, accel_y, accel_z, rate_x, rate_y (16 bits each, lowest first)
	input  wire logic [79:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// pitch_deg, roll_deg, avg_x, avg_y, avg_z (16 bits each, lowest first)
	output logic [79:0]      m_axis_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	localparam logic [4:0] OP_SCL_X = 5'd0;
	localparam logic [4:0] OP_SCL_Y = 5'd1;
	localparam logic [4:0] OP_SCL_Z = 5'd2;
	localparam logic [4:0] OP_SQ_X = 5'd3;
	localparam logic [4:0] OP_SQ_Y = 5'd4;
	localparam logic [4:0] OP_SQ_Z = 5'd5;
	localparam logic [4:0] OP_GYR_Y = 5'd6;
	localparam logic [4:0] OP_GYR_X = 5'd7;
	localparam logic [4:0] OP_PREV_P = 5'd8;
	localparam logic [4:0] OP_ACC_P = 5'd9;
	localparam logic [4:0] OP_GH_P = 5'd10;
	localparam logic [4:0] OP_GL_P = 5'd11;
	localparam logic [4:0] OP_PREV_R = 5'd12;
	localparam logic [4:0] OP_ACC_R = 5'd13;
	localparam logic [4:0] OP_GH_R = 5'd14;
	localparam logic [4:0] OP_GL_R = 5'd15;
	localparam logic [4:0] OP_DEG_P = 5'd16;
	localparam logic [4:0] OP_DEG_R = 5'd17;

	// configuration
	logic [15:0]        pitch_blend_q, roll_blend_q;
	logic signed [23:0] gyro_step_x_q, gyro_step_y_q;
	logic [15:0]        accel_scale_x_q, accel_scale_y_q, accel_scale_z_q;

	// filter state
	logic signed [15:0]      hist_x_q [AVG_DEPTH];
	logic signed [15:0]      hist_y_q [AVG_DEPTH];
	logic signed [15:0]      hist_z_q [AVG_DEPTH];
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic [SLOT_W-1:0]       slot_q;
	logic signed [RAD_W-1:0] pitch_rad_q, roll_rad_q;

	// per-item working registers
	state_t                  state_q, state_d;
	logic [4:0]              op_q;
	logic signed [15:0]      avg_x_q, avg_y_q, avg_z_q;
	logic signed [15:0]      rate_x_q, rate_y_q;
	logic signed [31:0]      sx_q, sy_q, sz_q;
	logic [63:0]             sqx_q, sqy_q, sqz_q;
	logic signed [40:0]      gp_q, gr_q;
	logic signed [ANG_W-1:0] ang_p_q, ang_r_q;
	logic signed [ACC_W-1:0] accp_q, accr_q;
	logic signed [15:0]      deg_p_q, deg_r_q;
	logic                    mul_vld_s1;
	logic [4:0]              mul_op_s1;
	logic                    m_valid_q;
	logic [79:0]             m_data_q;

	logic s_acc;
	logic issue;
	logic load_out;
	unit_ctl_t root_ctl, cord_ctl;
	unit_sts_t root_sts, cord_sts;
	logic [ROOT_W-1:0]       root;
	logic signed [ANG_W-1:0] angle;
	logic [RADIC_W-1:0]      radicand;
	logic signed [31:0]      cord_num;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p_s1;

	logic signed [15:0]      in_x, in_y, in_z;
	logic signed [SUM_W-1:0] nsum_x, nsum_y, nsum_z;
	logic [16:0]             wc_p, wc_r;
	logic signed [43:0]      deg_sum;
	logic signed [43:0]      deg_val;
	logic signed [15:0]      deg_sat;
	logic signed [ACC_W-1:0] prod_hi;

	assign in_x = $signed(s_axis_tdata[15:0]);
	assign in_y = $signed(s_axis_tdata[31:16]);
	assign in_z = $signed(s_axis_tdata[47:32]);
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// average toward zero
	function automatic logic signed [15:0] avg_of(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] b;
		b = s + (s[SUM_W-1] ? SUM_W'(AVG_DEPTH - 1) : SUM_W'(0));
		return 16'(b >>> AVG_SHIFT);
	endfunction

	// round and saturate a blend sum to the radian range
	function automatic logic signed [RAD_W-1:0] fuse(input logic signed [ACC_W-1:0] t);
		logic signed [ACC_W-1:0] r;
		r = (t + (ACC_W'(1) <<< 39)) >>> 40;
		if (r > ACC_W'(2 ** (RAD_W - 1) - 1)) return RAD_W'(2 ** (RAD_W - 1) - 1);
		if (r < -ACC_W'(2 ** (RAD_W - 1))) return RAD_W'(-(2 ** (RAD_W - 1)));
		return RAD_W'(r);
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_blend_q <= 16'd64225;
			roll_blend_q <= 16'd64225;
			gyro_step_x_q <= 24'sd146447;
			gyro_step_y_q <= 24'sd146447;
			accel_scale_x_q <= 16'd4096;
			accel_scale_y_q <= 16'd4096;
			accel_scale_z_q <= 16'd4096;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PITCH_BLEND: pitch_blend_q <= cfg_data[15:0];
				REG_ROLL_BLEND: roll_blend_q <= cfg_data[15:0];
				REG_GYRO_STEP_X: gyro_step_x_q <= $signed(cfg_data);
				REG_GYRO_STEP_Y: gyro_step_y_q <= $signed(cfg_data);
				REG_ACCEL_SCALE_X: accel_scale_x_q <= cfg_data[15:0];
				REG_ACCEL_SCALE_Y: accel_scale_y_q <= cfg_data[15:0];
				REG_ACCEL_SCALE_Z: accel_scale_z_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// window sums with the new sample in and the oldest out
	always_comb begin
		nsum_x = sum_x_q - SUM_W'(hist_x_q[slot_q]) + SUM_W'(in_x);
		nsum_y = sum_y_q - SUM_W'(hist_y_q[slot_q]) + SUM_W'(in_y);
		nsum_z = sum_z_q - SUM_W'(hist_z_q[slot_q]) + SUM_W'(in_z);
	end

	// boxcar ring and angle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < AVG_DEPTH; k++) begin
				hist_x_q[k] <= '0;
				hist_y_q[k] <= '0;
				hist_z_q[k] <= '0;
			end
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			slot_q <= '0;
			pitch_rad_q <= '0;
			roll_rad_q <= '0;
		end else begin
			if (s_acc) begin
				hist_x_q[slot_q] <= in_x;
				hist_y_q[slot_q] <= in_y;
				hist_z_q[slot_q] <= in_z;
				sum_x_q <= nsum_x;
				sum_y_q <= nsum_y;
				sum_z_q <= nsum_z;
				slot_q <= (slot_q == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end
			if (state_q == ST_FUSE) begin
				pitch_rad_q <= fuse(accp_q);
				roll_rad_q <= fuse(accr_q);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_acc) state_d = ST_MUL_A;
			ST_MUL_A: if (mul_vld_s1 && mul_op_s1 == OP_GYR_X) state_d = ST_ROOT_P;
			ST_ROOT_P: state_d = ST_ROOT_P_W;
			ST_ROOT_P_W: if (root_sts.done) state_d = ST_CORD_P;
			ST_CORD_P: state_d = ST_CORD_P_W;
			ST_CORD_P_W: if (cord_sts.done) state_d = ST_ROOT_R;
			ST_ROOT_R: state_d = ST_ROOT_R_W;
			ST_ROOT_R_W: if (root_sts.done) state_d = ST_CORD_R;
			ST_CORD_R: state_d = ST_CORD_R_W;
			ST_CORD_R_W: if (cord_sts.done) state_d = ST_MUL_B;
			ST_MUL_B: if (mul_vld_s1 && mul_op_s1 == OP_GL_R) state_d = ST_FUSE;
			ST_FUSE: state_d = ST_MUL_C;
			ST_MUL_C: if (mul_vld_s1 && mul_op_s1 == OP_DEG_R) state_d = ST_DONE;
			ST_DONE: if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		root_ctl.start = (state_q == ST_ROOT_P) || (state_q == ST_ROOT_R);
		cord_ctl.start = (state_q == ST_CORD_P) || (state_q == ST_CORD_R);
		issue = ((state_q == ST_MUL_A) && (op_q <= OP_GYR_X))
			|| ((state_q == ST_MUL_B) && (op_q <= OP_GL_R))
			|| ((state_q == ST_MUL_C) && (op_q <= OP_DEG_R));
		load_out = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= '0;
			mul_vld_s1 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_acc) op_q <= '0;
			else if (issue) op_q <= op_q + 1'b1;
			mul_vld_s1 <= issue;
			if (load_out) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	// multiplier operands for each step
	always_comb begin
		wc_p = 17'h10000 - {1'b0, pitch_blend_q};
		wc_r = 17'h10000 - {1'b0, roll_blend_q};
		case (op_q)
			OP_SCL_X: begin
				mul_a = MUL_W'(avg_x_q);
				mul_b = $signed({17'b0, accel_scale_x_q});
			end
			OP_SCL_Y: begin
				mul_a = MUL_W'(avg_y_q);
				mul_b = $signed({17'b0, accel_scale_y_q});
			end
			OP_SCL_Z: begin
				mul_a = MUL_W'(avg_z_q);
				mul_b = $signed({17'b0, accel_scale_z_q});
			end
			OP_SQ_X: begin
				mul_a = MUL_W'(sx_q);
				mul_b = MUL_W'(sx_q);
			end
			OP_SQ_Y: begin
				mul_a = MUL_W'(sy_q);
				mul_b = MUL_W'(sy_q);
			end
			OP_SQ_Z: begin
				mul_a = MUL_W'(sz_q);
				mul_b = MUL_W'(sz_q);
			end
			OP_GYR_Y: begin
				mul_a = MUL_W'(rate_y_q);
				mul_b = MUL_W'(gyro_step_y_q);
			end
			OP_GYR_X: begin
				mul_a = MUL_W'(rate_x_q);
				mul_b = MUL_W'(gyro_step_x_q);
			end
			OP_PREV_P: begin
				mul_a = $signed({17'b0, pitch_blend_q});
				mul_b = MUL_W'(pitch_rad_q);
			end
			OP_ACC_P: begin
				mul_a = $signed({16'b0, wc_p});
				mul_b = -MUL_W'(ang_p_q);
			end
			OP_GH_P: begin
				mul_a = $signed({17'b0, pitch_blend_q});
				mul_b = MUL_W'($signed(gp_q[40:24]));
			end
			OP_GL_P: begin
				mul_a = $signed({17'b0, pitch_blend_q});
				mul_b = $signed({9'b0, gp_q[23:0]});
			end
			OP_PREV_R: begin
				mul_a = $signed({17'b0, roll_blend_q});
				mul_b = MUL_W'(roll_rad_q);
			end
			OP_ACC_R: begin
				mul_a = $signed({16'b0, wc_r});
				mul_b = MUL_W'(ang_r_q);
			end
			OP_GH_R: begin
				mul_a = $signed({17'b0, roll_blend_q});
				mul_b = MUL_W'($signed(gr_q[40:24]));
			end
			OP_GL_R: begin
				mul_a = $signed({17'b0, roll_blend_q});
				mul_b = $signed({9'b0, gr_q[23:0]});
			end
			OP_DEG_P: begin
				mul_a = MUL_W'(pitch_rad_q);
				mul_b = MUL_W'(DEG_MUL);
			end
			OP_DEG_R: begin
				mul_a = MUL_W'(roll_rad_q);
				mul_b = MUL_W'(DEG_MUL);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// product terms: shifted blend part and rounded, saturated degrees
	always_comb begin
		prod_hi = $signed({mul_p_s1[41:0], 24'b0});
		deg_sum = $signed(mul_p_s1[43:0]) + 44'sd16777216;
		deg_val = deg_sum >>> 25;
		if (deg_val > 44'(DEG_LIM)) deg_sat = 16'(DEG_LIM);
		else if (deg_val < -44'(DEG_LIM)) deg_sat = -16'(DEG_LIM);
		else deg_sat = 16'(deg_val);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			avg_x_q <= avg_of(nsum_x);
			avg_y_q <= avg_of(nsum_y);
			avg_z_q <= avg_of(nsum_z);
			rate_x_q <= $signed(s_axis_tdata[63:48]);
			rate_y_q <= $signed(s_axis_tdata[79:64]);
			accp_q <= '0;
			accr_q <= '0;
		end else if (mul_vld_s1) begin
			case (mul_op_s1)
				OP_SCL_X: sx_q <= mul_p_s1[31:0];
				OP_SCL_Y: sy_q <= mul_p_s1[31:0];
				OP_SCL_Z: sz_q <= mul_p_s1[31:0];
				OP_SQ_X: sqx_q <= mul_p_s1[63:0];
				OP_SQ_Y: sqy_q <= mul_p_s1[63:0];
				OP_SQ_Z: sqz_q <= mul_p_s1[63:0];
				OP_GYR_Y: gp_q <= -$signed(mul_p_s1[40:0]);
				OP_GYR_X: gr_q <= mul_p_s1[40:0];
				OP_PREV_P, OP_ACC_P, OP_GH_P: accp_q <= accp_q + prod_hi;
				OP_GL_P: accp_q <= accp_q + mul_p_s1;
				OP_PREV_R, OP_ACC_R, OP_GH_R: accr_q <= accr_q + prod_hi;
				OP_GL_R: accr_q <= accr_q + mul_p_s1;
				OP_DEG_P: deg_p_q <= deg_sat;
				OP_DEG_R: deg_r_q <= deg_sat;
				default: ;
			endcase
		end
		mul_op_s1 <= op_q;
		if ((state_q == ST_CORD_P_W) && cord_sts.done) ang_p_q <= angle;
		if ((state_q == ST_CORD_R_W) && cord_sts.done) ang_r_q <= angle;
		if (load_out) m_data_q <= {avg_z_q, avg_y_q, avg_x_q, deg_r_q, deg_p_q};
	end

	// operands of the root and CORDIC passes
	always_comb begin
		radicand = (state_q == ST_ROOT_P) ? (sqy_q + sqz_q) : (sqx_q + sqz_q);
		cord_num = (state_q == ST_CORD_P) ? sx_q : sy_q;
	end

	tcf_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p_s1)
	);

	tcf_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (root_ctl),
		.radicand (radicand),
		.sts      (root_sts),
		.root     (root)
	);

	tcf_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cord_ctl),
		.num    (cord_num),
		.den    (root),
		.sts    (cord_sts),
		.angle  (angle)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;

endmodule
`default_nettype wire

/* sv/tcf_checker.sv */
// Port-level checks of the tilt filter, bound to the top level.
// Depends on tcf_pkg and tilt_complementary_filter_defines.svh.
`default_nettype none
`include "tilt_complementary_filter_defines.svh"
module tcf_checker import tcf_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [79:0] m_axis_tdata
);

	logic angles_ok;

	// both angles inside +-180 degrees
	always_comb begin
		angles_ok = ($signed(m_axis_tdata[15:0]) <= 16'(DEG_LIM))
			&& ($signed(m_axis_tdata[15:0]) >= -16'(DEG_LIM))
			&& ($signed(m_axis_tdata[31:16]) <= 16'(DEG_LIM))
			&& ($signed(m_axis_tdata[31:16]) >= -16'(DEG_LIM));
	end

	`TCF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`TCF_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`TCF_ASSERT_NEXT(a_busy_after_beat, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`TCF_ASSERT_IMPL(a_angle_range, m_axis_tvalid, angles_ok)

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (.*);
`default_nettype wire

/* tb/tb_tilt_complementary_filter.sv */
// Self-checking bench for the tilt filter: boxcar averages, CORDIC tilt and blend.
// Depends on tcf_pkg and the tilt_complementary_filter RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_tilt_complementary_filter;
	import tcf_pkg::*;

	typedef struct packed {
		logic signed [15:0] pitch_deg;
		logic signed [15:0] roll_deg;
		logic signed [15:0] avg_x;
		logic signed [15:0] avg_y;
		logic signed [15:0] avg_z;
	} attitude_t;

	localparam int WATCH_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;
	// index past the last register, must be ignored
	localparam logic [2:0] REG_UNKNOWN = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	// predictor state
	longint hist_x[AVG_DEPTH], hist_y[AVG_DEPTH], hist_z[AVG_DEPTH];
	longint win_x, win_y, win_z;
	int slot;
	longint pitch_q16, roll_q16;
	longint w_pitch, w_roll, step_x, step_y, scl_x, scl_y, scl_z;

	attitude_t expected_q[$];
	int errors = 0;
	int idle_cycles = 0;
	bit stall_heavy = 1'b0;

	tilt_complementary_filter u_dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint asr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint int_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint tilt_angle(longint num, longint den);
		longint x, y, z, tx, ty;
		x = den;
		y = num;
		z = 0;
		if (num == 0 && den == 0) return 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			tx = asr_floor(x, i);
			ty = asr_floor(y, i);
			if (y >= 0) begin
				x += ty; y -= tx; z += longint'(atan_q16(i[IDX_W-1:0]));
			end else begin
				x -= ty; y += tx; z -= longint'(atan_q16(i[IDX_W-1:0]));
			end
		end
		return z;
	endfunction

	function automatic longint fuse(longint prev, longint gyro, longint acc, longint w);
		longint t;
		t = w * (prev * (64'sd1 << 24) + gyro) + (65536 - w) * (acc * (64'sd1 << 24));
		return clip(asr_floor(t + (64'sd1 << 39), 40), -524288, 524287);
	endfunction

	function automatic longint deg_of_q16(longint rad);
		return clip(asr_floor(rad * DEG_MUL + (64'sd1 << 24), 25), -DEG_LIM, DEG_LIM);
	endfunction

	task automatic reset_model();
		w_pitch = 64225; w_roll = 64225;
		step_x = 146447; step_y = 146447;
		scl_x = 4096; scl_y = 4096; scl_z = 4096;
		foreach (hist_x[i]) begin
			hist_x[i] = 0; hist_y[i] = 0; hist_z[i] = 0;
		end
		win_x = 0; win_y = 0; win_z = 0;
		slot = 0;
		pitch_q16 = 0; roll_q16 = 0;
	endtask

	// compute the attitude beat that one sample produces
	task automatic predict_attitude(logic [79:0] d);
		longint ax, ay, az, rx, ry, sx, sy, sz, ang_p, ang_r;
		attitude_t r;
		rx = longint'($signed(d[63:48]));
		ry = longint'($signed(d[79:64]));
		win_x += longint'($signed(d[15:0])) - hist_x[slot];
		win_y += longint'($signed(d[31:16])) - hist_y[slot];
		win_z += longint'($signed(d[47:32])) - hist_z[slot];
		hist_x[slot] = longint'($signed(d[15:0]));
		hist_y[slot] = longint'($signed(d[31:16]));
		hist_z[slot] = longint'($signed(d[47:32]));
		slot = (slot + 1) % AVG_DEPTH;
		ax = win_x / AVG_DEPTH;
		ay = win_y / AVG_DEPTH;
		az = win_z / AVG_DEPTH;
		sx = ax * scl_x; sy = ay * scl_y; sz = az * scl_z;
		ang_p = tilt_angle(sx, int_root(sy * sy + sz * sz));
		ang_r = tilt_angle(sy, int_root(sx * sx + sz * sz));
		pitch_q16 = fuse(pitch_q16, -(ry * step_y), -ang_p, w_pitch);
		roll_q16 = fuse(roll_q16, rx * step_x, ang_r, w_roll);
		r.pitch_deg = 16'(deg_of_q16(pitch_q16));
		r.roll_deg = 16'(deg_of_q16(roll_q16));
		r.avg_x = 16'(ax); r.avg_y = 16'(ay); r.avg_z = 16'(az);
		expected_q.push_back(r);
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 200) : $urandom_range(0, 3);
		repeat (n) @(posedge clk);
	endtask

	// send one beat; drop valid and wait for the next edge before the next drive
	task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az, logic signed [15:0] rx, logic signed [15:0] ry,
			bit gaps);
		if (gaps && $urandom_range(0, 1)) idle_gap();
		s_axis_tdata <= {ry, rx, az, ay, ax};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_attitude({ry, rx, az, ay, ax});
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PITCH_BLEND: w_pitch = longint'(val[15:0]);
			REG_ROLL_BLEND: w_roll = longint'(val[15:0]);
			REG_GYRO_STEP_X: step_x = longint'($signed(val));
			REG_GYRO_STEP_Y: step_y = longint'($signed(val));
			REG_ACCEL_SCALE_X: scl_x = longint'(val[15:0]);
			REG_ACCEL_SCALE_Y: scl_y = longint'(val[15:0]);
			REG_ACCEL_SCALE_Z: scl_z = longint'(val[15:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	// hold until every expected beat has arrived, then let the core settle
	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_samples(int n, int mode);
		logic signed [15:0] a;
		for (int i = 0; i < n; i++) begin
			a = (mode == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 8000)) - 4000);
			send_sample(a, 16'($urandom), (mode == 2) ? 16'sd0 : 16'($urandom),
				16'($urandom), 16'($urandom), 1'b1);
		end
	endtask

	task automatic test_directed();
		send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_sample(16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_sample(-16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_sample(16'sd0, 16'sh7fff, 16'sd0, 16'sh7fff, 16'sh7fff, 1'b0);
		send_sample(16'sd0, -16'sh8000, 16'sd0, -16'sh8000, -16'sh8000, 1'b0);
		send_sample(16'sd0, 16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 1'b0);
		send_sample(16'sd0, 16'sd0, -16'sh8000, 16'sd0, 16'sd0, 1'b0);
		// full-scale gyro and accelerometer samples, repeated
		for (int i = 0; i < 10; i++)
			send_sample(-16'sh8000, -16'sh8000, -16'sh8000, 16'sh7fff, -16'sh8000, 1'b0);
		for (int i = 0; i < 8; i++)
			send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, 16'sh7fff, 1'b0);
	endtask

	task automatic test_config_extremes();
		drain();
		write_reg(REG_PITCH_BLEND, 24'h0);
		write_reg(REG_ROLL_BLEND, 24'hffff);
		write_reg(REG_GYRO_STEP_X, 24'h7fffff);
		write_reg(REG_GYRO_STEP_Y, 24'h800000);
		write_reg(REG_ACCEL_SCALE_X, 24'hffff);
		write_reg(REG_ACCEL_SCALE_Y, 24'h0);
		write_reg(REG_ACCEL_SCALE_Z, 24'h1);
		write_reg(REG_UNKNOWN, 24'hffffff);
		random_samples(150, 0);
		drain();
		write_reg(REG_PITCH_BLEND, 24'hffff);
		write_reg(REG_ROLL_BLEND, 24'h0);
		write_reg(REG_GYRO_STEP_X, 24'h800000);
		write_reg(REG_GYRO_STEP_Y, 24'h7fffff);
		write_reg(REG_ACCEL_SCALE_X, 24'h0);
		write_reg(REG_ACCEL_SCALE_Y, 24'hffff);
		write_reg(REG_ACCEL_SCALE_Z, 24'hffff);
		random_samples(150, 2);
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 6; p++) begin
			drain();
			for (int r = 0; r < 7; r++) write_reg(r[2:0], 24'($urandom));
			stall_heavy = p[0];
			random_samples(80, p % 3);
		end
		stall_heavy = 1'b0;
		drain();
		write_reg(REG_PITCH_BLEND, 24'd64225);
		write_reg(REG_ROLL_BLEND, 24'd64225);
		write_reg(REG_GYRO_STEP_X, 24'd146447);
		write_reg(REG_GYRO_STEP_Y, 24'd146447);
		write_reg(REG_ACCEL_SCALE_X, 24'd4096);
		write_reg(REG_ACCEL_SCALE_Y, 24'd4096);
		write_reg(REG_ACCEL_SCALE_Z, 24'd4096);
		random_samples(240, 1);
		random_samples(200, 0);
	endtask

	// randomize the result-side stall
	always @(posedge clk) begin
		if (stall_heavy)
			m_axis_tready <= ($urandom_range(0, 3) == 0);
		else
			m_axis_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : 1'b1;
	end

	// compare each attitude beat with the oldest prediction
	always @(posedge clk) begin
		attitude_t got, exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.pitch_deg = m_axis_tdata[15:0];
			got.roll_deg = m_axis_tdata[31:16];
			got.avg_x = m_axis_tdata[47:32];
			got.avg_y = m_axis_tdata[63:48];
			got.avg_z = m_axis_tdata[79:64];
			if (expected_q.size() == 0) begin
				$error("unexpected output beat %h", m_axis_tdata);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (got.pitch_deg !== exp_r.pitch_deg) begin
					$error("pitch_deg exp %0d got %0d", exp_r.pitch_deg, got.pitch_deg);
					errors++;
				end
				if (got.roll_deg !== exp_r.roll_deg) begin
					$error("roll_deg exp %0d got %0d", exp_r.roll_deg, got.roll_deg);
					errors++;
				end
				if (got.avg_x !== exp_r.avg_x) begin
					$error("avg_x exp %0d got %0d", exp_r.avg_x, got.avg_x);
					errors++;
				end
				if (got.avg_y !== exp_r.avg_y) begin
					$error("avg_y exp %0d got %0d", exp_r.avg_y, got.avg_y);
					errors++;
				end
				if (got.avg_z !== exp_r.avg_z) begin
					$error("avg_z exp %0d got %0d", exp_r.avg_z, got.avg_z);
					errors++;
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCH_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random_settings();
		drain();
		if (errors == 0 && expected_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
+incdir+sv
sv/tcf_pkg.sv
sv/tcf_mul.sv
sv/tcf_isqrt.sv
sv/tcf_cordic.sv
sv/tilt_complementary_filter.sv
sv/tcf_checker.sv
tb/tb_tilt_complementary_filter.sv
